### src/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

    localparam int CAPACITY_DEFAULT = 1024;
    localparam int KEY_W            = 32;
    localparam int VAL_W            = 32;
    localparam int HASH_SHIFT       = 16;
    localparam int STATUS_W         = 3;
    localparam int SLOT_OUT_W       = 10;
    localparam int COUNT_OUT_W      = 11;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // one table slot: valid flag, key and value share a memory word
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage
`default_nettype wire

### src/lpht_mem.sv
`default_nettype none
module lpht_mem
    import lpht_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEFAULT,
    parameter int AW    = $clog2(CAPACITY_DEFAULT)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, one read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/lpht_hash.sv
`default_nettype none
module lpht_hash
    import lpht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT,
    parameter int AW       = $clog2(CAPACITY_DEFAULT)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [KEY_W-1:0] key,
    output logic                  done,
    output logic [AW-1:0]         home
);

    localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

    logic [KEY_W-1:0] hash;

    assign hash = key ^ (key >> HASH_SHIFT);

    generate
        if (IS_POW2)
        begin : g_mask
            logic          done_reg;
            logic [AW-1:0] home_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    home_reg <= hash[AW-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
        else
        begin : g_mod
            // hash mod CAPACITY by reciprocal multiply; the quotient estimate
            // is low by at most one, so a single compare and subtract ends it
            localparam logic [KEY_W-1:0] RECIP =
                KEY_W'((64'd1 << KEY_W) / 64'(CAPACITY));
            localparam logic [KEY_W-1:0] CAP = KEY_W'(CAPACITY);

            logic                 quot_go_reg;
            logic                 rem_go_reg;
            logic                 fix_go_reg;
            logic                 done_reg;
            logic [KEY_W-1:0]     h_reg;
            logic [KEY_W-1:0]     quot_reg;
            logic [KEY_W-1:0]     rem_reg;
            logic [KEY_W-1:0]     home_reg;
            logic [2*KEY_W-1:0]   product;

            assign product = (2*KEY_W)'(h_reg) * (2*KEY_W)'(RECIP);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    quot_go_reg <= 1'b0;
                    rem_go_reg  <= 1'b0;
                    fix_go_reg  <= 1'b0;
                    done_reg    <= 1'b0;
                end
                else
                begin
                    quot_go_reg <= start;
                    rem_go_reg  <= quot_go_reg;
                    fix_go_reg  <= rem_go_reg;
                    done_reg    <= fix_go_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    h_reg <= hash;
                end
                if (quot_go_reg)
                begin
                    quot_reg <= product[2*KEY_W-1:KEY_W];
                end
                if (rem_go_reg)
                begin
                    rem_reg <= h_reg - quot_reg * CAP;
                end
                if (fix_go_reg)
                begin
                    home_reg <= (rem_reg >= CAP) ? rem_reg - CAP : rem_reg;
                end
            end

            assign done = done_reg;
            assign home = home_reg[AW-1:0];
        end
    endgenerate

endmodule
`default_nettype wire

### src/linear_probe_hash_table_unit.sv
`default_nettype none
// Flow: the key is hashed to a home slot, then P slots are probed (1 <= P <= CAPACITY) until a
// hit, an empty slot or the last slot; a modulo hash is used when CAPACITY is not a power of two.
// One item at a time: the next is taken only once the result is loaded, which is delayed while the
// previous result still waits on m_axis_tready. s_axis_tready is low while an item is in flight.
// Reset: async, active low. After reset the table runs a clearing pass over all CAPACITY slots,
// one slot per cycle, with s_axis_tready low.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input items
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,  // key[31:0], value[63:32], default_value[95:64]
    input  wire logic         s_axis_tuser,  // operation[0]
    // result items
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [55:0]       m_axis_tdata,  // value_out[31:0], slot[41:32],
                                             // entry_count[52:42], zero pad[55:53]
    output logic [2:0]        m_axis_tuser   // status[2:0]
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_HASH  = 2'd2;
    localparam logic [1:0] S_PROBE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [AW-1:0]    slot_reg, slot_next;    // probe slot, also clear index
    logic [AW-1:0]    probe_reg, probe_next;  // slots already passed over
    logic [CNT_W-1:0] count_reg, count_next;
    logic             op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] dflt_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [VAL_W-1:0]    out_value_reg, out_value_next;
    logic [AW-1:0]       out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;

    logic          accept;
    logic          hash_done;
    logic [AW-1:0] hash_home;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_q;

    logic          hit, empty, last, decide, out_free;
    logic [AW-1:0] slot_inc;

    logic [31:0] slot_wide;
    logic [31:0] count_wide;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    lpht_hash #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (s_axis_tdata[31:0]),
        .done  (hash_done),
        .home  (hash_home)
    );

    lpht_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    // probe decision on the slot whose word just came out of memory
    assign hit      = mem_q.valid && (mem_q.key == key_reg);
    assign empty    = !mem_q.valid;
    assign last     = (probe_reg == AW'(CAPACITY - 1));
    assign decide   = hit || empty || last;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign slot_inc = (slot_reg == AW'(CAPACITY - 1)) ? '0 : slot_reg + AW'(1);

    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_reg;
        mem_wdata       = '{valid: 1'b1, key: key_reg, value: value_reg};
        mem_raddr       = slot_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (slot_reg == AW'(CAPACITY - 1))
                begin
                    slot_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                mem_raddr = hash_home;
                if (hash_done)
                begin
                    slot_next  = hash_home;
                    probe_next = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!decide)
                begin
                    slot_next  = slot_inc;
                    probe_next = probe_reg + AW'(1);
                    mem_raddr  = slot_inc;
                end
                else if (out_free)
                begin
                    // finish: load output; insert writes table unless full
                    out_valid_next = 1'b1;
                    out_slot_next  = slot_reg;
                    state_next     = S_IDLE;
                    if (op_reg == OP_INSERT)
                    begin
                        out_value_next = '0;
                        if (hit)
                        begin
                            out_status_next = ST_REPLACED;
                            mem_we          = 1'b1;
                        end
                        else if (empty)
                        begin
                            out_status_next = ST_NEW;
                            mem_we          = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            out_status_next = ST_FULL;
                            out_slot_next   = '0;
                        end
                    end
                    else
                    begin
                        if (hit)
                        begin
                            out_status_next = ST_HIT;
                            out_value_next  = mem_q.value;
                        end
                        else
                        begin
                            out_status_next = ST_MISS;
                            out_value_next  = dflt_reg;
                            out_slot_next   = '0;
                        end
                    end
                    out_count_next = count_next;
                end
                // else: output still busy, re-read the same slot and hold
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            slot_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg      <= probe_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
        if (accept)
        begin
            op_reg    <= s_axis_tuser;
            key_reg   <= s_axis_tdata[31:0];
            value_reg <= s_axis_tdata[63:32];
            dflt_reg  <= s_axis_tdata[95:64];
        end
    end

    // fit slot and count to the fixed result field widths
    assign slot_wide  = 32'(out_slot_reg);
    assign count_wide = 32'(out_count_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000,
                            count_wide[COUNT_OUT_W-1:0],
                            slot_wide[SLOT_OUT_W-1:0],
                            out_value_reg};

endmodule
`default_nettype wire
